// File: hw/rtl/i2cram_pkg.sv
// Package for the I2C register access master: item kinds, queue beat type, constants.
// No dependencies; imported by i2cram_front, i2cram_engine and the top level.
package i2cram_pkg;

    localparam int WRITE_BUF_DEPTH_DEF = 16;
    localparam logic [15:0] HALF_DELAY_RESET = 16'd20;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd100;
    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic RD_BIT = 1'b1;

    localparam logic CFG_HALF_DELAY = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_LOAD  = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    // one classified input beat as it sits in the queue
    typedef struct packed {
        logic       is_tick;
        logic       is_load;
        logic       is_start;
        logic       is_read;
        logic       sda_in;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] data_byte;
        logic [7:0] byte_count;
        logic       sccb_split;
    } t_item;

endpackage

// File: hw/rtl/i2cram_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module i2cram_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/i2cram_front.sv
// Front end: accepts input beats, classifies the kind, holds them in a two-entry queue.
// Depends on i2cram_pkg.
module i2cram_front
    import i2cram_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [39:0] i_data,
    output logic        o_head_valid,
    output t_item       o_head,
    input  logic        i_pop
);
    t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item w_in;
    t_kind w_kind;
    logic w_push;

    assign w_kind = t_kind'(i_kind);

    always_comb begin
        w_in.is_tick    = (w_kind == K_TICK);
        w_in.is_load    = (w_kind == K_LOAD);
        w_in.is_start   = (w_kind == K_WRITE) || (w_kind == K_READ);
        w_in.is_read    = (w_kind == K_READ);
        w_in.sda_in     = i_data[0];
        w_in.dev_addr   = i_data[7:1];
        w_in.reg_addr   = i_data[15:8];
        w_in.data_byte  = i_data[23:16];
        w_in.byte_count = i_data[31:24];
        w_in.sccb_split = i_data[32];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end
endmodule

// File: hw/rtl/i2cram_engine.sv
// Back end: bus phase sequencer, write buffer, config registers and output register.
// Depends on i2cram_pkg and i2cram_ram.
module i2cram_engine
    import i2cram_pkg::*;
#(
    parameter int WRITE_BUF_DEPTH = WRITE_BUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_head_valid,
    input  t_item       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_data,
    output logic        o_last
);
    localparam int AW = (WRITE_BUF_DEPTH > 1) ? $clog2(WRITE_BUF_DEPTH) : 1;
    localparam int FW = $clog2(WRITE_BUF_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(WRITE_BUF_DEPTH);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_TX1, PH_TX2, PH_TX3, PH_AK1, PH_AK2, PH_AKP,
        PH_RX1, PH_RX2, PH_RK1, PH_RK2, PH_SP1, PH_SP2, PH_MS1, PH_MS2,
        PH_ES1, PH_ES2
    } t_phase;

    typedef enum logic [2:0] {
        SG_ADDRW, SG_REG, SG_DATA, SG_ADDRR, SG_READ
    } t_stage;

    t_phase r_phase, n_phase;
    t_stage r_stage, n_stage;
    logic [15:0] r_timer, n_timer;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shreg, n_shreg;
    logic [7:0] r_left, n_left;
    logic [7:0] r_polls, n_polls;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_pos, n_pos;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [1:0] r_mode, n_mode;
    logic [15:0] r_half;
    logic [7:0] r_ato;

    logic r_ovalid;
    logic [15:0] r_odata, n_odata;
    logic r_olast, n_olast;

    logic w_we;
    logic [7:0] w_rdata;
    logic w_next_write, w_advance;
    logic w_scl, w_so, w_drv, w_rv, w_rl, w_done, w_err;
    logic [7:0] w_rd;
    logic [15:0] w_len;

    i2cram_ram #(.WIDTH(8), .DEPTH(WRITE_BUF_DEPTH), .AW(AW)) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_head.data_byte),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_pop = i_head_valid && (!r_ovalid || i_ready);
    assign w_len = (r_half == 16'd0) ? 16'd1 : r_half;

    always_comb begin
        n_phase = r_phase; n_stage = r_stage; n_timer = r_timer; n_bit = r_bit;
        n_shreg = r_shreg; n_left = r_left; n_polls = r_polls; n_fill = r_fill;
        n_pos = r_pos; n_dev = r_dev; n_reg = r_reg; n_mode = r_mode;
        w_we = 1'b0; w_next_write = 1'b0; w_advance = 1'b0;
        w_scl = 1'b1; w_so = 1'b1; w_drv = 1'b0;
        w_rv = 1'b0; w_rd = 8'd0; w_rl = 1'b0; w_done = 1'b0; w_err = 1'b0;

        if (!i_head.is_tick) begin
            if (r_phase == PH_IDLE) begin
                if (i_head.is_load) begin
                    if (r_fill < FULL) begin
                        w_we = o_pop;
                        n_fill = r_fill + FW'(1);
                    end
                end else if (i_head.is_start) begin
                    n_dev = i_head.dev_addr;
                    n_reg = i_head.reg_addr;
                    n_stage = SG_ADDRW;
                    n_pos = '0;
                    n_bit = 4'd0;
                    n_polls = 8'd0;
                    if (!i_head.is_read) begin
                        n_mode = 2'b00;
                        n_left = ({1'b0, i_head.byte_count} < 9'(r_fill))
                               ? i_head.byte_count : 8'(r_fill);
                    end else begin
                        n_mode = {i_head.sccb_split, 1'b1};
                        n_left = (i_head.byte_count == 8'd0) ? 8'd1 : i_head.byte_count;
                    end
                    n_phase = PH_ST1;
                    n_timer = 16'd0;
                end
            end
        end else begin
            case (r_phase)
                PH_ST1: begin w_scl = 1'b1; w_so = 1'b1; w_drv = 1'b1; end
                PH_ST2: begin w_scl = 1'b1; w_so = 1'b0; w_drv = 1'b1; end
                PH_TX1, PH_TX3: begin
                    w_scl = 1'b0; w_so = |(r_shreg & MSB_MASK); w_drv = 1'b1;
                end
                PH_TX2: begin w_scl = 1'b1; w_so = |(r_shreg & MSB_MASK); w_drv = 1'b1; end
                PH_AK1, PH_RX1: w_scl = 1'b0;
                PH_RK1: begin w_scl = 1'b0; w_so = (r_left == 8'd0); w_drv = 1'b1; end
                PH_RK2: begin w_scl = 1'b1; w_so = (r_left == 8'd0); w_drv = 1'b1; end
                PH_SP1, PH_MS1, PH_ES1: begin w_scl = 1'b0; w_so = 1'b0; w_drv = 1'b1; end
                PH_SP2, PH_MS2, PH_ES2: begin w_scl = 1'b1; w_so = 1'b1; w_drv = 1'b1; end
                default: ;
            endcase

            if (r_phase == PH_AKP) begin
                if (!i_head.sda_in) begin
                    // acknowledged: move on by stage
                    case (r_stage)
                        SG_ADDRW: begin
                            n_shreg = r_reg; n_stage = SG_REG; n_bit = 4'd0;
                            n_phase = PH_TX1; n_timer = 16'd0;
                        end
                        SG_REG: begin
                            if (r_mode[0]) begin
                                n_stage = SG_ADDRR;
                                n_phase = r_mode[1] ? PH_MS1 : PH_ST1;
                                n_timer = 16'd0;
                            end else begin
                                w_next_write = 1'b1;
                            end
                        end
                        SG_DATA: w_next_write = 1'b1;
                        SG_ADDRR: begin
                            n_stage = SG_READ; n_bit = 4'd0; n_shreg = 8'd0;
                            n_phase = PH_RX1; n_timer = 16'd0;
                        end
                        default: begin n_phase = PH_SP1; n_timer = 16'd0; end
                    endcase
                end else if (r_polls >= r_ato) begin
                    n_phase = PH_ES1; n_timer = 16'd0;
                end else begin
                    n_polls = r_polls + 8'd1;
                end
            end else if (r_phase != PH_IDLE) begin
                if (r_phase == PH_RX2 && r_timer == 16'd0 && r_bit < 4'd8) begin
                    n_shreg = {r_shreg[6:0], i_head.sda_in};
                    n_bit = r_bit + 4'd1;
                    if (n_bit == 4'd8) begin
                        w_rv = 1'b1;
                        w_rd = n_shreg;
                        w_rl = (r_left <= 8'd1);
                        if (r_left != 8'd0) begin
                            n_left = r_left - 8'd1;
                        end
                    end
                end
                if ({1'b0, r_timer} + 17'd1 >= {1'b0, w_len}) begin
                    w_advance = 1'b1;
                end else begin
                    n_timer = r_timer + 16'd1;
                end
            end

            if (w_advance) begin
                n_timer = 16'd0;
                case (r_phase)
                    PH_ST1: n_phase = PH_ST2;
                    PH_ST2: begin
                        n_shreg = {r_dev, (r_stage == SG_ADDRR) ? RD_BIT : 1'b0};
                        n_bit = 4'd0;
                        n_phase = PH_TX1;
                    end
                    PH_TX1: n_phase = PH_TX2;
                    PH_TX2: n_phase = PH_TX3;
                    PH_TX3: begin
                        n_shreg = {r_shreg[6:0], 1'b0};
                        n_bit = r_bit + 4'd1;
                        if (n_bit >= 4'd8) begin
                            n_polls = 8'd0;
                            n_phase = PH_AK1;
                        end else begin
                            n_phase = PH_TX1;
                        end
                    end
                    PH_AK1: n_phase = PH_AK2;
                    PH_AK2: n_phase = PH_AKP;
                    PH_RX1: n_phase = PH_RX2;
                    PH_RX2: n_phase = (n_bit >= 4'd8) ? PH_RK1 : PH_RX1;
                    PH_RK1: n_phase = PH_RK2;
                    PH_RK2: begin
                        if (r_left != 8'd0) begin
                            n_bit = 4'd0; n_shreg = 8'd0; n_phase = PH_RX1;
                        end else begin
                            n_phase = PH_SP1;
                        end
                    end
                    PH_SP1: n_phase = PH_SP2;
                    PH_MS1: n_phase = PH_MS2;
                    PH_MS2: n_phase = PH_ST1;
                    PH_ES1: n_phase = PH_ES2;
                    PH_SP2, PH_ES2: begin
                        if (!r_mode[0]) begin
                            n_fill = '0;
                        end
                        n_phase = PH_IDLE;
                        w_done = 1'b1;
                        w_err = (r_phase == PH_ES2);
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end

            if (w_next_write) begin
                n_timer = 16'd0;
                if (r_left == 8'd0) begin
                    n_phase = PH_SP1;
                end else begin
                    n_shreg = w_rdata;
                    n_pos = r_pos + FW'(1);
                    n_left = r_left - 8'd1;
                    n_stage = SG_DATA;
                    n_bit = 4'd0;
                    n_phase = PH_TX1;
                end
            end
        end

        n_odata = {1'b0, w_err, w_done, w_rd, w_rv, (n_phase != PH_IDLE), w_drv, w_so, w_scl};
        n_olast = w_rl;
        if (!o_pop) begin
            n_odata = r_odata;
            n_olast = r_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_stage <= SG_ADDRW;
            r_timer <= 16'd0;
            r_bit <= 4'd0;
            r_shreg <= 8'd0;
            r_left <= 8'd0;
            r_polls <= 8'd0;
            r_fill <= '0;
            r_pos <= '0;
            r_dev <= 7'd0;
            r_reg <= 8'd0;
            r_mode <= 2'b00;
            r_half <= HALF_DELAY_RESET;
            r_ato <= ACK_TIMEOUT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase; r_stage <= n_stage; r_timer <= n_timer;
                r_bit <= n_bit; r_shreg <= n_shreg; r_left <= n_left;
                r_polls <= n_polls; r_fill <= n_fill; r_pos <= n_pos;
                r_dev <= n_dev; r_reg <= n_reg; r_mode <= n_mode;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HALF_DELAY: r_half <= i_cfg_wdata;
                    CFG_ACK_TIMEOUT: r_ato <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_odata;
    assign o_last = r_olast;
endmodule

// File: hw/rtl/i2c_register_access_master_core.sv
// Top level of the I2C register access master: front queue plus bus engine.
// Depends on i2cram_pkg, i2cram_front, i2cram_engine (and i2cram_ram below it).
//
// Each input beat is one bus tick (or a command: load a write byte, start a write or
// read transaction) and yields exactly one output beat with the SCL/SDA levels for
// that tick plus status. One beat per clock is sustained: the front queue (two
// entries) and the output register let input and output stall independently, and the
// engine retires one beat per cycle whenever the output register is free or being
// drained. An accepted beat is registered in the front queue, then in the output register.
// Config writes (half_delay, ack_timeout) take effect on the next edge; issue them only
// while no beat is in flight. The write buffer is a small RAM prefetched by its read
// pointer, so no clearing pass is needed.
module i2c_register_access_master_core
    import i2cram_pkg::*;
#(
    parameter int WRITE_BUF_DEPTH = WRITE_BUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port: index 0 half_delay, index 1 ack_timeout
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: sda_in[0], dev_addr[7:1], reg_addr[15:8], data_byte[23:16],
    //        byte_count[31:24], sccb_split[32], zero fill[39:33]
    input  logic [39:0] i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: scl[0], sda_out[1], sda_drive[2], busy_res[3], read_valid[4],
    //        read_data[12:5], done_res[13], ack_error[14], zero fill[15]
    output logic [15:0] o_m_axis_tdata,
    // tlast: read_last
    output logic        o_m_axis_tlast
);
    logic  w_head_valid;
    t_item w_head;
    logic  w_pop;

    i2cram_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser),
        .i_data       (i_s_axis_tdata),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    i2cram_engine #(.WRITE_BUF_DEPTH(WRITE_BUF_DEPTH)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );
endmodule

// File: hw/rtl/i2cram_checker.sv
// Port-level checker for the I2C register access master, bound to the top level.
// Depends only on the top level's ports.
module i2cram_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[4])
        else $error("read_last without read_valid");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[14] |-> o_m_axis_tdata[13] && !o_m_axis_tdata[3])
        else $error("ack_error without done or while busy");

    a_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[2] |-> o_m_axis_tdata[1])
        else $error("released SDA must read as high");
endmodule

bind i2c_register_access_master_core i2cram_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: bench/tb_i2c_register_access_master_core.sv
`timescale 1ns / 1ps
// Self-checking bench for i2c_register_access_master_core: drives tick/command beats,
// predicts every output beat with a local bus-phase model. Depends on i2cram_pkg.
module tb_i2c_register_access_master_core;
    import i2cram_pkg::*;

    localparam int BUF_DEPTH = WRITE_BUF_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    // bus phases and byte stages of the predictor
    typedef enum int {
        P_IDLE, P_ST1, P_ST2, P_TX1, P_TX2, P_TX3, P_AK1, P_AK2, P_AKP,
        P_RX1, P_RX2, P_RK1, P_RK2, P_SP1, P_SP2, P_MS1, P_MS2, P_ES1, P_ES2
    } t_phase;
    typedef enum int { S_ADDRW, S_REG, S_DATA, S_ADDRR, S_READ } t_stage;

    typedef struct packed {
        logic       last;
        logic [15:0] data;
    } t_bus_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    i2c_register_access_master_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---- predictor state ----
    logic [15:0] m_half;
    logic [7:0]  m_tmo;
    t_phase      m_ph;
    t_stage      m_stg;
    logic [15:0] m_tmr;
    int          m_bit;
    logic [7:0]  m_sh, m_left, m_polls, m_dev, m_reg;
    logic [7:0]  m_buf [BUF_DEPTH];
    int          m_fill, m_pos;
    logic        m_rd, m_sccb;

    t_bus_beat   expected_beats[$];
    int          err_count = 0;
    int          cycles = 0;
    int          beats_seen = 0;
    bit          run_done = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch beat %0d %s: got %0h want %0h", beats_seen, what, got, want);
        err_count++;
    endtask

    function automatic void bus_go(input t_phase p);
        m_ph = p;
        m_tmr = 0;
    endfunction

    function automatic void next_data_byte();
        if (m_left == 0) begin
            bus_go(P_SP1);
            return;
        end
        m_sh = (m_pos < BUF_DEPTH) ? m_buf[m_pos] : 8'h00;
        m_pos++;
        m_left--;
        m_stg = S_DATA;
        m_bit = 0;
        bus_go(P_TX1);
    endfunction

    function automatic void on_ack();
        case (m_stg)
            S_ADDRW: begin
                m_sh = m_reg; m_stg = S_REG; m_bit = 0; bus_go(P_TX1);
            end
            S_REG: begin
                if (m_rd) begin
                    m_stg = S_ADDRR;
                    bus_go(m_sccb ? P_MS1 : P_ST1);
                end else next_data_byte();
            end
            S_DATA: next_data_byte();
            S_ADDRR: begin
                m_stg = S_READ; m_bit = 0; m_sh = 0; bus_go(P_RX1);
            end
            default: bus_go(P_SP1);
        endcase
    endfunction

    function automatic void close_txn(ref logic done, ref logic err, input logic e);
        if (!m_rd) m_fill = 0;
        bus_go(P_IDLE);
        done = 1'b1;
        err = e;
    endfunction

    function automatic void next_phase(ref logic done, ref logic err);
        case (m_ph)
            P_ST1: bus_go(P_ST2);
            P_ST2: begin
                m_sh = {m_dev[6:0], (m_stg == S_ADDRR) ? RD_BIT : 1'b0};
                m_bit = 0;
                bus_go(P_TX1);
            end
            P_TX1: bus_go(P_TX2);
            P_TX2: bus_go(P_TX3);
            P_TX3: begin
                m_sh = m_sh << 1;
                m_bit++;
                if (m_bit >= 8) begin
                    m_polls = 0; bus_go(P_AK1);
                end else bus_go(P_TX1);
            end
            P_AK1: bus_go(P_AK2);
            P_AK2: bus_go(P_AKP);
            P_RX1: bus_go(P_RX2);
            P_RX2: bus_go(m_bit >= 8 ? P_RK1 : P_RX1);
            P_RK1: bus_go(P_RK2);
            P_RK2: begin
                if (m_left != 0) begin
                    m_bit = 0; m_sh = 0; bus_go(P_RX1);
                end else bus_go(P_SP1);
            end
            P_SP1: bus_go(P_SP2);
            P_SP2: close_txn(done, err, 1'b0);
            P_MS1: bus_go(P_MS2);
            P_MS2: bus_go(P_ST1);
            P_ES1: bus_go(P_ES2);
            P_ES2: close_txn(done, err, 1'b1);
            default: bus_go(P_IDLE);
        endcase
    endfunction

    // One input beat in, one expected output beat out.
    function automatic t_bus_beat bus_tick(input t_kind kind, input logic [39:0] d);
        t_bus_beat r;
        logic scl, so, drv, rv, rl, done, err;
        logic [7:0] rdata, bc;
        logic [16:0] len;
        scl = 1; so = 1; drv = 0; rv = 0; rl = 0; done = 0; err = 0; rdata = 0;
        if (kind != K_TICK) begin
            if (m_ph == P_IDLE) begin
                if (kind == K_LOAD) begin
                    if (m_fill < BUF_DEPTH) begin
                        m_buf[m_fill] = d[23:16];
                        m_fill++;
                    end
                end else begin
                    bc = d[31:24];
                    m_dev = {1'b0, d[7:1]};
                    m_reg = d[15:8];
                    m_stg = S_ADDRW;
                    m_pos = 0; m_bit = 0; m_polls = 0;
                    if (kind == K_WRITE) begin
                        m_rd = 0; m_sccb = 0;
                        m_left = (bc < m_fill) ? bc : m_fill[7:0];
                    end else begin
                        m_rd = 1; m_sccb = d[32];
                        m_left = (bc == 0) ? 8'd1 : bc;
                    end
                    bus_go(P_ST1);
                end
            end
        end else begin
            case (m_ph)
                P_ST1: begin scl = 1; so = 1; drv = 1; end
                P_ST2: begin scl = 1; so = 0; drv = 1; end
                P_TX1, P_TX3: begin scl = 0; so = m_sh[7]; drv = 1; end
                P_TX2: begin scl = 1; so = m_sh[7]; drv = 1; end
                P_AK1, P_RX1: scl = 0;
                P_RK1: begin scl = 0; so = (m_left == 0); drv = 1; end
                P_RK2: begin scl = 1; so = (m_left == 0); drv = 1; end
                P_SP1, P_MS1, P_ES1: begin scl = 0; so = 0; drv = 1; end
                P_SP2, P_MS2, P_ES2: begin scl = 1; so = 1; drv = 1; end
                default: ;
            endcase
            if (m_ph == P_AKP) begin
                if (!d[0]) on_ack();
                else if (m_polls >= m_tmo) bus_go(P_ES1);
                else m_polls++;
            end else if (m_ph != P_IDLE) begin
                len = (m_half == 0) ? 17'd1 : {1'b0, m_half};
                if (m_ph == P_RX2 && m_tmr == 0 && m_bit < 8) begin
                    m_sh = {m_sh[6:0], d[0]};
                    m_bit++;
                    if (m_bit == 8) begin
                        rv = 1; rdata = m_sh; rl = (m_left <= 1);
                        if (m_left != 0) m_left--;
                    end
                end
                if ({1'b0, m_tmr} + 17'd1 >= len) next_phase(done, err);
                else m_tmr++;
            end
        end
        r.data = {1'b0, err, done, rdata, rv, (m_ph != P_IDLE), drv, so, scl};
        r.last = rl;
        return r;
    endfunction

    // ---- output side: random stalls, compare against oldest expectation ----
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[i2c_register_access_master_core] ERROR");
            $finish;
        end
    end

    initial begin
        int gap;
        t_bus_beat w;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!run_done) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 1)) gap = 0;
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            // beat taken at this edge
            if (expected_beats.size() == 0) begin
                report("unexpected beat", o_m_axis_tdata, 0);
            end else begin
                w = expected_beats.pop_front();
                if (o_m_axis_tdata[2:0] !== w.data[2:0])
                    report("scl/sda/drive", o_m_axis_tdata[2:0], w.data[2:0]);
                if (o_m_axis_tdata[3] !== w.data[3]) report("busy", o_m_axis_tdata[3], w.data[3]);
                if (o_m_axis_tdata[12:4] !== w.data[12:4])
                    report("read valid/data", o_m_axis_tdata[12:4], w.data[12:4]);
                if (o_m_axis_tdata[14:13] !== w.data[14:13])
                    report("done/ack_error", o_m_axis_tdata[14:13], w.data[14:13]);
                if (o_m_axis_tlast !== w.last) report("read_last", o_m_axis_tlast, w.last);
            end
            beats_seen++;
        end
    end

    // ---- input side ----
    int sent = 0;

    // valid stays up between back-to-back beats; it drops only across a gap
    task automatic send_beat(input t_kind kind, input logic [39:0] d, input bit check_fixed,
                             input logic [15:0] want);
        int gap;
        t_bus_beat e;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        e = bus_tick(kind, d);
        if (check_fixed && e.data !== want) report("table row vs predictor", e.data, want);
        expected_beats.push_back(e);
        sent++;
    endtask

    function automatic logic [39:0] pack_cmd(input logic sda, input logic [6:0] dev,
        input logic [7:0] rg, input logic [7:0] db, input logic [7:0] bc, input logic sc);
        return {7'd0, sc, bc, db, rg, dev, sda};
    endfunction

    task automatic drain_idle();
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] v);
        drain_idle();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HALF_DELAY) m_half = v;
        else m_tmo = v[7:0];
    endtask

    // Plays the slave: ticks until idle, ack low except with nack_pct percent chance, read data random.
    task automatic run_bus(input int nack_pct);
        logic s;
        int n;
        n = 0;
        while (m_ph != P_IDLE && n < 20000) begin
            if (m_ph == P_AKP) s = ($urandom_range(0, 99) < nack_pct);
            else s = $urandom_range(0, 1);
            send_beat(K_TICK, pack_cmd(s, $urandom, $urandom, $urandom, $urandom, $urandom),
                      0, 0);
            n++;
        end
    endtask

    // directed table: kind, tdata, whether the expected beat is fixed, that beat
    typedef struct {
        t_kind       kind;
        logic [39:0] d;
        bit          fixed;
        logic [15:0] want;
    } t_row;

    initial begin
        t_row rows[$];
        int k, nb;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_addr = 1'b0; i_cfg_wdata = 16'd0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = 40'd0; i_s_axis_tuser = K_TICK;
        m_half = HALF_DELAY_RESET; m_tmo = ACK_TIMEOUT_RESET;
        m_ph = P_IDLE; m_stg = S_ADDRW; m_tmr = 0; m_bit = 0; m_sh = 0; m_left = 0;
        m_polls = 0; m_dev = 0; m_reg = 0; m_fill = 0; m_pos = 0; m_rd = 0; m_sccb = 0;
        for (k = 0; k < BUF_DEPTH; k++) m_buf[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: idle ticks show released bus, loads answer idle levels
        rows.push_back('{K_TICK, 40'd0, 1, 16'h0003});
        rows.push_back('{K_TICK, 40'hFF_FFFF_FFFF, 1, 16'h0003});
        rows.push_back('{K_LOAD, pack_cmd(0, 0, 0, 8'hFF, 0, 0), 1, 16'h0003});
        rows.push_back('{K_LOAD, pack_cmd(1, 7'h7F, 8'hFF, 8'h00, 8'hFF, 1), 1, 16'h0003});
        rows.push_back('{K_LOAD, pack_cmd(0, 0, 0, 8'hA5, 0, 0), 1, 16'h0003});
        // start write with count above fill: busy goes up, idle levels
        rows.push_back('{K_WRITE, pack_cmd(0, 7'h7F, 8'h00, 0, 8'hFF, 0), 1, 16'h000B});
        // commands while busy are ignored
        rows.push_back('{K_LOAD, pack_cmd(0, 0, 0, 8'h11, 0, 0), 1, 16'h000B});
        rows.push_back('{K_READ, pack_cmd(0, 0, 0, 0, 0, 1), 1, 16'h000B});
        foreach (rows[i]) send_beat(rows[i].kind, rows[i].d, rows[i].fixed, rows[i].want);

        // zero delay, quick phases
        write_cfg(CFG_HALF_DELAY, 16'd0);
        run_bus(0);
        drain_idle();
        write_cfg(CFG_ACK_TIMEOUT, 8'd1);
        write_cfg(CFG_HALF_DELAY, 16'd1);
        // ack timeout on a write
        send_beat(K_LOAD, pack_cmd(0, 0, 0, 8'h3C, 0, 0), 0, 0);
        send_beat(K_WRITE, pack_cmd(0, 7'h00, 8'hFF, 0, 8'd1, 0), 0, 0);
        run_bus(100);
        // reads: count zero, sccb split, plain
        send_beat(K_READ, pack_cmd(0, 7'h55, 8'h12, 0, 8'd0, 1), 0, 0);
        run_bus(0);
        send_beat(K_READ, pack_cmd(0, 7'h2A, 8'hED, 0, 8'd2, 0), 0, 0);
        run_bus(0);
        // write with count 0 sends only address and register
        send_beat(K_WRITE, pack_cmd(0, 7'h01, 8'h80, 0, 8'd0, 0), 0, 0);
        run_bus(0);
        // fill buffer past depth
        for (k = 0; k < BUF_DEPTH + 2; k++)
            send_beat(K_LOAD, pack_cmd(0, 0, 0, $urandom, 0, 0), 0, 0);
        send_beat(K_WRITE, pack_cmd(0, 7'h40, 8'h01, 0, 8'd3, 0), 0, 0);
        run_bus(0);
        drain_idle();

        // a stretch at the widest delay, then a short phase ends it on the next tick
        write_cfg(CFG_HALF_DELAY, 16'hFFFF);
        write_cfg(CFG_ACK_TIMEOUT, 8'd255);
        send_beat(K_WRITE, pack_cmd(0, 7'h33, 8'h44, 0, 8'd0, 0), 0, 0);
        for (k = 0; k < 20; k++)
            send_beat(K_TICK, pack_cmd($urandom, 0, 0, 0, 0, 0), 0, 0);
        write_cfg(CFG_HALF_DELAY, 16'd1);
        while (m_ph != P_IDLE) begin
            if (m_ph == P_AKP) send_beat(K_TICK, 40'd0, 0, 0);
            else send_beat(K_TICK, {39'd0, 1'b1}, 0, 0);
        end
        drain_idle();
        write_cfg(CFG_ACK_TIMEOUT, 8'd100);

        while (sent < 1100) begin
            write_cfg(CFG_HALF_DELAY, $urandom_range(0, 3) == 0 ? 16'd0 : $urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_ACK_TIMEOUT, $urandom_range(1, 4));
            nb = $urandom_range(0, 5);
            for (k = 0; k < nb; k++) begin
                send_beat(K_LOAD, pack_cmd($urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom), 0, 0);
            end
            k = $urandom_range(0, 9);
            if (k < 4) send_beat(K_WRITE, pack_cmd($urandom, $urandom, $urandom, $urandom,
                                                   $urandom_range(0, 6), $urandom), 0, 0);
            else if (k < 8) send_beat(K_READ, pack_cmd($urandom, $urandom, $urandom, $urandom,
                                                       $urandom_range(0, 3), $urandom), 0, 0);
            else send_beat(t_kind'($urandom_range(1, 3)),
                           pack_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom), 0, 0);
            // noise: commands mid-transaction
            if ($urandom_range(0, 3) == 0) begin
                send_beat(t_kind'($urandom_range(1, 3)),
                          pack_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom), 0, 0);
            end
            run_bus($urandom_range(0, 4) == 0 ? 60 : 2);
            drain_idle();
        end

        drain_idle();
        run_done = 1;
        if (expected_beats.size() != 0) begin
            $display("missing %0d beats", expected_beats.size());
            err_count++;
        end
        if (err_count == 0) $display("[i2c_register_access_master_core] OK");
        else $display("[i2c_register_access_master_core] ERROR");
        $finish;
    end
endmodule
